// File: rtl/icalc_pkg.sv
// Shared types, codes and constants for the two-operand infix calculator.
package icalc_pkg;

    localparam int OPERAND_BITS_DEF  = 23;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_BITS        = 64;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SYNTAX   = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_OVERFLOW = 3'd4
    } st_t;

    typedef struct packed {
        logic neg;
        op_t  op;
        st_t  err;
    } ctl_t;

    localparam int CTL_BITS = $bits(ctl_t);

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [2:0] st_rank(st_t code);
        logic [2:0] r;
        unique case (code)
            ST_SYNTAX:   r = 3'd4;
            ST_OVERFLOW: r = 3'd3;
            ST_UNKNOWN:  r = 3'd2;
            ST_DIVZERO:  r = 3'd1;
            default:     r = 3'd0;
        endcase
        return r;
    endfunction

    // keep the higher-priority error
    function automatic st_t st_pick(st_t cur, st_t code);
        return (st_rank(code) > st_rank(cur)) ? code : cur;
    endfunction

endpackage

// File: rtl/icalc_ch_if.sv
// Character input channel: one ASCII character per beat.
interface icalc_ch_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// File: rtl/icalc_res_if.sv
// Result output channel: fixed-point value and status per beat.
interface icalc_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// File: rtl/icalc_fifo.sv
// Small flip-flop queue carrying parsed expressions from front to back.
module icalc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = icalc_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rd_data,
    output icalc_pkg::q_stat_t    stat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/icalc_front.sv
// Front end: character parser that builds operands, operator and error status.
module icalc_front #(
    parameter int OPERAND_BITS = icalc_pkg::OPERAND_BITS_DEF,
    parameter int JOB_BITS     = icalc_pkg::CTL_BITS + 2 * OPERAND_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    icalc_ch_if.sink             chars,
    input  icalc_pkg::q_stat_t   q_stat,
    output logic                 push,
    output logic [JOB_BITS-1:0]  job
);
    localparam int ACC_BITS = OPERAND_BITS + 4;
    localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = {OPERAND_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_START,
        PH_FIRST_DIGIT,
        PH_IN_FIRST,
        PH_SECOND_DIGIT,
        PH_IN_SECOND,
        PH_DRAIN
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [OPERAND_BITS-1:0] left_reg, left_next;
    logic [OPERAND_BITS-1:0] right_reg, right_next;
    icalc_pkg::op_t          op_reg, op_next;
    icalc_pkg::st_t          err_reg, err_next;

    logic                    accept;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [OPERAND_BITS-1:0] acc_src;
    logic [ACC_BITS-1:0]     acc_x, acc_wide;
    logic                    acc_ovf;
    logic [OPERAND_BITS-1:0] dig_val;
    icalc_pkg::st_t          err_dig, err_end1, err_end2;
    icalc_pkg::ctl_t         job_ctl;

    assign chars.ready = !q_stat.full;
    assign accept      = chars.valid && chars.ready;
    assign is_digit    = (chars.ch >= icalc_pkg::CH_ZERO) && (chars.ch <= icalc_pkg::CH_NINE);
    assign digit       = 4'(chars.ch - icalc_pkg::CH_ZERO);

    // shared decimal accumulator: acc * 10 + digit, saturating
    always_comb
    begin
        unique case (phase_reg)
            PH_IN_FIRST:  acc_src = left_reg;
            PH_IN_SECOND: acc_src = right_reg;
            default:      acc_src = '0;
        endcase
    end

    assign acc_x    = ACC_BITS'(acc_src);
    assign acc_wide = (acc_x << 3) + (acc_x << 1) + ACC_BITS'(digit);
    assign acc_ovf  = acc_wide > ACC_BITS'(OPERAND_MAX);
    assign dig_val  = acc_ovf ? OPERAND_MAX : acc_wide[OPERAND_BITS-1:0];
    assign err_dig  = acc_ovf ? icalc_pkg::st_pick(err_reg, icalc_pkg::ST_OVERFLOW) : err_reg;

    // end-of-expression checks
    assign err_end1 = (phase_reg != PH_IN_SECOND)
                      ? icalc_pkg::st_pick(err_reg, icalc_pkg::ST_SYNTAX) : err_reg;
    assign err_end2 = (op_reg == icalc_pkg::OP_DIV && right_reg == '0)
                      ? icalc_pkg::st_pick(err_end1, icalc_pkg::ST_DIVZERO) : err_end1;

    assign job_ctl.neg = neg_reg;
    assign job_ctl.op  = op_reg;
    assign job_ctl.err = err_end2;
    assign job         = {job_ctl, left_reg, right_reg};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        left_next  = left_reg;
        right_next = right_reg;
        op_next    = op_reg;
        err_next   = err_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (chars.ch == icalc_pkg::CH_NUL)
            begin
                push       = 1'b1;
                phase_next = PH_START;
                neg_next   = 1'b0;
                left_next  = '0;
                right_next = '0;
                op_next    = icalc_pkg::OP_ADD;
                err_next   = icalc_pkg::ST_OK;
            end
            else if (chars.ch != icalc_pkg::CH_SPACE)
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (chars.ch == icalc_pkg::CH_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_FIRST_DIGIT;
                        end
                        else if (is_digit)
                        begin
                            left_next  = dig_val;
                            err_next   = err_dig;
                            phase_next = PH_IN_FIRST;
                        end
                        else
                        begin
                            err_next   = icalc_pkg::st_pick(err_reg, icalc_pkg::ST_SYNTAX);
                            phase_next = PH_DRAIN;
                        end
                    end
                    PH_FIRST_DIGIT:
                    begin
                        if (is_digit)
                        begin
                            left_next  = dig_val;
                            err_next   = err_dig;
                            phase_next = PH_IN_FIRST;
                        end
                        else
                        begin
                            err_next   = icalc_pkg::st_pick(err_reg, icalc_pkg::ST_SYNTAX);
                            phase_next = PH_DRAIN;
                        end
                    end
                    PH_IN_FIRST:
                    begin
                        if (is_digit)
                        begin
                            left_next = dig_val;
                            err_next  = err_dig;
                        end
                        else
                        begin
                            unique case (chars.ch)
                                icalc_pkg::CH_PLUS:  op_next = icalc_pkg::OP_ADD;
                                icalc_pkg::CH_MINUS: op_next = icalc_pkg::OP_SUB;
                                icalc_pkg::CH_STAR:  op_next = icalc_pkg::OP_MUL;
                                icalc_pkg::CH_SLASH: op_next = icalc_pkg::OP_DIV;
                                default:
                                    err_next = icalc_pkg::st_pick(err_reg, icalc_pkg::ST_UNKNOWN);
                            endcase
                            phase_next = PH_SECOND_DIGIT;
                        end
                    end
                    PH_SECOND_DIGIT:
                    begin
                        if (is_digit)
                        begin
                            right_next = dig_val;
                            err_next   = err_dig;
                            phase_next = PH_IN_SECOND;
                        end
                        else
                        begin
                            err_next   = icalc_pkg::st_pick(err_reg, icalc_pkg::ST_SYNTAX);
                            phase_next = PH_DRAIN;
                        end
                    end
                    PH_IN_SECOND:
                    begin
                        if (is_digit)
                        begin
                            right_next = dig_val;
                            err_next   = err_dig;
                        end
                        else
                        begin
                            err_next   = icalc_pkg::st_pick(err_reg, icalc_pkg::ST_SYNTAX);
                            phase_next = PH_DRAIN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            left_reg  <= '0;
            right_reg <= '0;
            op_reg    <= icalc_pkg::OP_ADD;
            err_reg   <= icalc_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            op_reg    <= op_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: rtl/icalc_back.sv
// Back end: arithmetic unit with iterative divider and registered result beat.
module icalc_back #(
    parameter int OPERAND_BITS  = icalc_pkg::OPERAND_BITS_DEF,
    parameter int FRACTION_BITS = icalc_pkg::FRACTION_BITS_DEF,
    parameter int JOB_BITS      = icalc_pkg::CTL_BITS + 2 * OPERAND_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  icalc_pkg::q_stat_t   q_stat,
    input  logic [JOB_BITS-1:0]  job,
    output logic                 pop,
    icalc_res_if.source          results
);
    localparam int VB = icalc_pkg::VALUE_BITS;
    localparam int DW = OPERAND_BITS + FRACTION_BITS;
    localparam int CW = $clog2(DW);

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_DIV
    } bk_state_t;

    bk_state_t               state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VB-1:0]           value_reg, value_next;
    icalc_pkg::st_t          status_reg, status_next;
    logic                    neg_reg, neg_next;
    logic [OPERAND_BITS-1:0] div_b_reg, div_b_next;
    logic [OPERAND_BITS-1:0] rem_reg, rem_next;
    logic [DW-1:0]           quo_reg, quo_next;
    logic [CW-1:0]           cnt_reg, cnt_next;

    icalc_pkg::ctl_t           ctl;
    logic [OPERAND_BITS-1:0]   op_a, op_b;
    logic [VB-1:0]             a64, b64, sa, arith;
    logic [2*OPERAND_BITS-1:0] prod;
    logic [VB-1:0]             prod_sh;
    logic                      out_free;
    logic [OPERAND_BITS:0]     rem_sh;
    logic                      ge;
    logic [OPERAND_BITS:0]     rem_sub;
    logic [DW-1:0]             quo_step;
    logic [VB-1:0]             q64;

    assign ctl  = icalc_pkg::ctl_t'(job[JOB_BITS-1 -: icalc_pkg::CTL_BITS]);
    assign op_a = job[2*OPERAND_BITS-1 -: OPERAND_BITS];
    assign op_b = job[OPERAND_BITS-1:0];

    assign a64     = VB'(op_a);
    assign b64     = VB'(op_b);
    assign sa      = ctl.neg ? (VB'(0) - a64) : a64;
    assign prod    = op_a * op_b;
    assign prod_sh = VB'(prod) << FRACTION_BITS;

    always_comb
    begin
        unique case (ctl.op)
            icalc_pkg::OP_ADD: arith = (sa + b64) << FRACTION_BITS;
            icalc_pkg::OP_SUB: arith = (sa - b64) << FRACTION_BITS;
            default:           arith = ctl.neg ? (VB'(0) - prod_sh) : prod_sh;
        endcase
    end

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {rem_reg, quo_reg[DW-1]};
    assign ge       = rem_sh >= {1'b0, div_b_reg};
    assign rem_sub  = ge ? (rem_sh - {1'b0, div_b_reg}) : rem_sh;
    assign quo_step = {quo_reg[DW-2:0], ge};
    assign q64      = VB'(quo_step);

    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !results.ready;
        value_next     = value_reg;
        status_next    = status_reg;
        neg_next       = neg_reg;
        div_b_next     = div_b_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        pop            = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop = 1'b1;
                    if (ctl.err != icalc_pkg::ST_OK)
                    begin
                        out_valid_next = 1'b1;
                        value_next     = '0;
                        status_next    = ctl.err;
                    end
                    else if (ctl.op == icalc_pkg::OP_DIV)
                    begin
                        state_next = BK_DIV;
                        neg_next   = ctl.neg;
                        div_b_next = op_b;
                        rem_next   = '0;
                        quo_next   = DW'(op_a) << FRACTION_BITS;
                        cnt_next   = CW'(DW - 1);
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        value_next     = arith;
                        status_next    = icalc_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                rem_next = rem_sub[OPERAND_BITS-1:0];
                quo_next = quo_step;
                if (cnt_reg == '0)
                begin
                    // output register is empty here: it drained when the job was taken
                    state_next     = BK_IDLE;
                    out_valid_next = 1'b1;
                    value_next     = neg_reg ? (VB'(0) - q64) : q64;
                    status_next    = icalc_pkg::ST_OK;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= icalc_pkg::ST_OK;
            neg_reg       <= 1'b0;
            div_b_reg     <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
            neg_reg       <= neg_next;
            div_b_reg     <= div_b_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = value_reg;
    assign results.status = status_reg;

endmodule

// File: rtl/infix_two_operand_expression_evaluator.sv
// Top level of the two-operand infix calculator: parser, queue and arithmetic back end.
// Takes one ASCII character per beat; spaces are skipped and a zero byte closes the
// expression and yields one result beat (Q47.16 value and status; value is zero on any
// error). The parser takes a character every cycle as long as the two-entry expression
// queue has room. Add, subtract and multiply results are registered in the back end and
// appear in the cycle after the queue hands them over; divide runs on a restoring divider
// at one quotient bit per cycle. The divider, and a result beat that is not taken, hold up
// following expressions. Characters stall only while two finished expressions wait in the
// queue.
module infix_two_operand_expression_evaluator #(
    parameter int OPERAND_BITS  = icalc_pkg::OPERAND_BITS_DEF,
    parameter int FRACTION_BITS = icalc_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    icalc_ch_if.sink     chars,
    icalc_res_if.source  results
);
    localparam int JOB_BITS = icalc_pkg::CTL_BITS + 2 * OPERAND_BITS;

    logic                q_push, q_pop;
    logic [JOB_BITS-1:0] q_wr_data, q_rd_data;
    icalc_pkg::q_stat_t  q_stat;
    icalc_pkg::ctl_t     head_ctl;

    icalc_front #(
        .OPERAND_BITS (OPERAND_BITS),
        .JOB_BITS     (JOB_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_stat (q_stat),
        .push   (q_push),
        .job    (q_wr_data)
    );

    icalc_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (icalc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    icalc_back #(
        .OPERAND_BITS  (OPERAND_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .JOB_BITS      (JOB_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .job     (q_rd_data),
        .pop     (q_pop),
        .results (results)
    );

    assign head_ctl = icalc_pkg::ctl_t'(q_rd_data[JOB_BITS-1 -: icalc_pkg::CTL_BITS]);

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.status != icalc_pkg::ST_OK |-> results.value == '0)
        else $error("error result carries a nonzero value");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("expression pushed into a full queue");

    a_err_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && head_ctl.err != icalc_pkg::ST_OK
        |=> results.valid && results.status == $past(head_ctl.err))
        else $error("errored expression did not produce its status beat");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the two-operand infix calculator (character in, result out).
module tb_top;
    import icalc_pkg::*;

    localparam int OPND_BITS  = OPERAND_BITS_DEF;
    localparam int FRAC_BITS  = FRACTION_BITS_DEF;
    localparam logic [31:0] OPND_MAX = (32'd1 << OPND_BITS) - 32'd1;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef enum logic [2:0] {
        PH_START,
        PH_FIRST_DIGIT,
        PH_IN_FIRST,
        PH_SECOND_DIGIT,
        PH_IN_SECOND,
        PH_DRAIN
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    icalc_ch_if  chars_if();
    icalc_res_if res_if();

    infix_two_operand_expression_evaluator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if)
    );

    always #1 clk = ~clk;

    // expression tracker
    parse_phase_t expr_phase;
    logic         expr_neg;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    op_t          expr_op;
    st_t          expr_err;

    logic [63:0]  pending_value[$];
    st_t          pending_status[$];

    bit idle_en;
    int chars_sent;
    int fail_count;
    int stall_left;
    int idle_cycles;

    function automatic int err_priority(st_t code);
        case (code)
            ST_SYNTAX:   return 4;
            ST_OVERFLOW: return 3;
            ST_UNKNOWN:  return 2;
            ST_DIVZERO:  return 1;
            default:     return 0;
        endcase
    endfunction

    function automatic void note_error(st_t code);
        if (err_priority(code) > err_priority(expr_err))
            expr_err = code;
    endfunction

    function automatic logic [31:0] shift_in_digit(logic [31:0] acc, logic [7:0] c);
        logic [31:0] nxt;
        nxt = acc * 32'd10 + {24'd0, c - CH_ZERO};
        if (nxt > OPND_MAX) begin
            note_error(ST_OVERFLOW);
            return OPND_MAX;
        end
        return nxt;
    endfunction

    function automatic void clear_expression();
        expr_phase = PH_START;
        expr_neg   = 1'b0;
        lhs        = '0;
        rhs        = '0;
        expr_op    = OP_ADD;
        expr_err   = ST_OK;
    endfunction

    function automatic void close_expression();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sa;
        logic [63:0] v;
        if (expr_phase != PH_IN_SECOND)
            note_error(ST_SYNTAX);
        if (expr_op == OP_DIV && rhs == 0)
            note_error(ST_DIVZERO);
        v = '0;
        if (expr_err == ST_OK) begin
            a  = {32'd0, lhs};
            b  = {32'd0, rhs};
            sa = expr_neg ? -a : a;
            case (expr_op)
                OP_ADD: v = (sa + b) << FRAC_BITS;
                OP_SUB: v = (sa - b) << FRAC_BITS;
                OP_MUL:
                begin
                    v = (a * b) << FRAC_BITS;
                    if (expr_neg)
                        v = -v;
                end
                default:
                begin
                    v = (a << FRAC_BITS) / b;
                    if (expr_neg)
                        v = -v;
                end
            endcase
        end
        pending_value.push_back(v);
        pending_status.push_back(expr_err);
        clear_expression();
    endfunction

    function automatic void track_char(logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_NUL) begin
            close_expression();
            return;
        end
        if (c == CH_SPACE)
            return;
        case (expr_phase)
            PH_START:
            begin
                if (c == CH_MINUS) begin
                    expr_neg   = 1'b1;
                    expr_phase = PH_FIRST_DIGIT;
                end else if (is_digit) begin
                    lhs        = shift_in_digit('0, c);
                    expr_phase = PH_IN_FIRST;
                end else begin
                    note_error(ST_SYNTAX);
                    expr_phase = PH_DRAIN;
                end
            end
            PH_FIRST_DIGIT:
            begin
                if (is_digit) begin
                    lhs        = shift_in_digit('0, c);
                    expr_phase = PH_IN_FIRST;
                end else begin
                    note_error(ST_SYNTAX);
                    expr_phase = PH_DRAIN;
                end
            end
            PH_IN_FIRST:
            begin
                if (is_digit) begin
                    lhs = shift_in_digit(lhs, c);
                end else begin
                    case (c)
                        CH_PLUS:  expr_op = OP_ADD;
                        CH_MINUS: expr_op = OP_SUB;
                        CH_STAR:  expr_op = OP_MUL;
                        CH_SLASH: expr_op = OP_DIV;
                        default:  note_error(ST_UNKNOWN);
                    endcase
                    expr_phase = PH_SECOND_DIGIT;
                end
            end
            PH_SECOND_DIGIT:
            begin
                if (is_digit) begin
                    rhs        = shift_in_digit('0, c);
                    expr_phase = PH_IN_SECOND;
                end else begin
                    note_error(ST_SYNTAX);
                    expr_phase = PH_DRAIN;
                end
            end
            PH_IN_SECOND:
            begin
                if (is_digit) begin
                    rhs = shift_in_digit(rhs, c);
                end else begin
                    note_error(ST_SYNTAX);
                    expr_phase = PH_DRAIN;
                end
            end
            default: ;
        endcase
    endfunction

    // any nonzero byte that is neither a digit nor a space
    function automatic logic [7:0] odd_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || (c >= CH_ZERO && c <= CH_NINE));
        return c;
    endfunction

    function automatic string pick_operand();
        case ($urandom_range(0, 15))
            8, 9, 10: return $sformatf("%0d", $urandom_range(0, OPND_MAX));
            11:       return $sformatf("%0d", OPND_MAX);
            12:       return $sformatf("%0d", OPND_MAX + 1);
            13:       return "99999999999";
            14:       return "0";
            15:       return $sformatf("000%0d", $urandom_range(0, 9));
            default:  return $sformatf("%0d", $urandom_range(0, 999));
        endcase
    endfunction

    task automatic send_char(logic [7:0] c);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.ch    <= c;
        do
            @(negedge clk);
        while (!chars_if.ready);
        @(posedge clk);
        chars_sent++;
        track_char(c);
    endtask

    task automatic send_expr(string s, bit spaced);
        for (int i = 0; i < s.len(); i++) begin
            if (spaced && $urandom_range(0, 7) == 0)
                send_char(CH_SPACE);
            send_char(s[i]);
        end
        send_char(CH_NUL);
    endtask

    task automatic test_directed();
        send_expr("", 0);
        send_expr("-", 0);
        send_expr("3+", 0);
        send_expr("1?2", 0);
        send_expr("7/0", 0);
        send_expr("9+1x", 0);
        send_expr("-4*3", 0);
        send_expr("88888888/0", 0);
    endtask

    task automatic test_expressions(int upto);
        string     a;
        string     b;
        string     s;
        logic [7:0] op;
        while (chars_sent < upto) begin
            a = pick_operand();
            b = pick_operand();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:     op = CH_PLUS;
                5, 6, 7, 8, 9:     op = CH_MINUS;
                10, 11, 12, 13, 14: op = CH_STAR;
                19:                op = odd_char();
                default:           op = CH_SLASH;
            endcase
            if (op == CH_SLASH && $urandom_range(0, 3) == 0)
                b = "0";
            s = $sformatf("%s%s%c%s", ($urandom_range(0, 2) == 0) ? "-" : "", a, op, b);
            case ($urandom_range(0, 11))
                0: s = $sformatf("%s%c", a, op);
                1: s = $sformatf("%s%c", s, odd_char());
                2: s = $sformatf("-%s", s);
                default: ;
            endcase
            send_expr(s, 1);
        end
    endtask

    task automatic test_noise(int upto);
        logic [7:0] c;
        while (chars_sent < upto) begin
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 3))
                    0:       c = 8'($urandom_range(CH_ZERO, CH_NINE));
                    1:       c = odd_char();
                    default: c = 8'($urandom_range(1, 255));
                endcase
                send_char(c);
            end
            send_char(CH_NUL);
        end
    endtask

    initial
    begin
        res_if.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [63:0] want_value;
        st_t         want_status;
        forever
        begin
            @(negedge clk);
            if (rst_n && res_if.valid && res_if.ready) begin
                if (pending_value.size() == 0) begin
                    $error("unexpected result beat: value %h status %0d",
                           res_if.value, res_if.status);
                    fail_count++;
                end else begin
                    want_value  = pending_value.pop_front();
                    want_status = pending_status.pop_front();
                    if (res_if.value !== want_value) begin
                        $error("value: expected %h, got %h", want_value, res_if.value);
                        fail_count++;
                    end
                    if (res_if.status !== want_status) begin
                        $error("status: expected %0d, got %0d", want_status, res_if.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.ch    <= CH_NUL;
        idle_en    = 1'b1;
        chars_sent = 0;
        fail_count = 0;
        clear_expression();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_expressions(650);
        test_noise(850);
        idle_en = 1'b0;
        test_expressions(1100);
        chars_if.valid <= 1'b0;

        while (pending_value.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_value.size() != 0) begin
            $error("%0d expected results never arrived", pending_value.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: infix_two_operand_expression_evaluator.f
rtl/icalc_pkg.sv
rtl/icalc_ch_if.sv
rtl/icalc_res_if.sv
rtl/icalc_fifo.sv
rtl/icalc_front.sv
rtl/icalc_back.sv
rtl/infix_two_operand_expression_evaluator.sv
verif/tb_top.sv
